// ===== rtl/ps2mf_pkg.sv =====
// Shared types and constants for the PS/2 mouse packet store.
package ps2mf_pkg;

  localparam int PKT_W = 24;
  localparam int REQ_W = 6;
  localparam int QUOT_W = 5;

  localparam logic [7:0] SYNC_MASK = 8'h08;

  localparam logic [1:0] ST_DELIVERED = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_SHORT = 2'd2;

  typedef enum logic [1:0] {
    PH_FIRST  = 2'd0,
    PH_SECOND = 2'd1,
    PH_THIRD  = 2'd2
  } phase_t;

  typedef enum logic [1:0] {
    CS_IDLE   = 2'd0,
    CS_STATUS = 2'd1,
    CS_DATA   = 2'd2
  } ctl_state_t;

  typedef struct packed {
    logic [7:0] b0;
    logic [7:0] b1;
    logic [7:0] b2;
  } pkt_t;

  typedef struct packed {
    logic valid;
    pkt_t pkt;
  } frame_t;

endpackage

// ===== rtl/ps2mf_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module ps2mf_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== rtl/ps2mf_framer.sv =====
// Byte framer: assembles three mouse bytes into one packet, syncing on bit 3.
module ps2mf_framer (
  input  logic              clk,
  input  logic              rst,
  input  logic              byte_valid,
  input  logic [7:0]        data_byte,
  output ps2mf_pkg::frame_t frame
);

  ps2mf_pkg::phase_t phase;
  ps2mf_pkg::phase_t phase_next;
  logic [7:0] held_first;
  logic [7:0] held_second;
  logic       cap_first;
  logic       cap_second;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= ps2mf_pkg::PH_FIRST;
    end else begin
      phase <= phase_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cap_first) begin
      held_first <= data_byte;
    end
    if (cap_second) begin
      held_second <= data_byte;
    end
  end

  always_comb begin
    phase_next = phase;
    cap_first = 1'b0;
    cap_second = 1'b0;
    frame.valid = 1'b0;
    frame.pkt = '{b0: held_first, b1: held_second, b2: data_byte};
    unique case (phase)
      ps2mf_pkg::PH_SECOND: begin
        if (byte_valid) begin
          cap_second = 1'b1;
          phase_next = ps2mf_pkg::PH_THIRD;
        end
      end
      ps2mf_pkg::PH_THIRD: begin
        if (byte_valid) begin
          frame.valid = 1'b1;
          phase_next = ps2mf_pkg::PH_FIRST;
        end
      end
      default: begin
        // unused code behaves as awaiting first byte
        if (byte_valid) begin
          if ((data_byte & ps2mf_pkg::SYNC_MASK) != 8'h00) begin
            cap_first = 1'b1;
            phase_next = ps2mf_pkg::PH_SECOND;
          end else begin
            phase_next = ps2mf_pkg::PH_FIRST;
          end
        end
      end
    endcase
  end

endmodule

// ===== rtl/ps2_mouse_packet_fifo_unit.sv =====
// PS/2 mouse packet store: framer, packet ring memory and read sequencer.
//
// Items are taken one at a time. A mouse byte (mode 0) is accepted and yields
// no result; every third framed byte writes one packet into the ring memory
// unless it already holds STORE_PACKETS packets. A read request (mode 1) is
// accepted, then the sequencer drains its packets through the memory's single
// registered read port, one per cycle while the output is not stalled; an
// empty or short request gets a single status reply. The input stalls until
// the last result of a request is loaded into the output register. The memory
// needs no clearing after reset; entries are only read after being written.
module ps2_mouse_packet_fifo_unit #(
  parameter int STORE_PACKETS = 256,
  parameter int MAX_READ_PACKETS = 16
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic       mode,
  input  logic [7:0] data_byte,
  input  logic [5:0] requested_bytes,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [1:0] status,
  output logic [7:0] first_byte,
  output logic [7:0] second_byte,
  output logic [7:0] third_byte,
  output logic       last
);

  localparam int ADDR_W = $clog2(STORE_PACKETS);
  localparam int CNT_W = $clog2(STORE_PACKETS + 1);
  localparam int RCNT_W = $clog2(MAX_READ_PACKETS + 1);
  localparam int CMP_A = (CNT_W > RCNT_W) ? CNT_W : RCNT_W;
  localparam int CMP_W = (CMP_A > ps2mf_pkg::QUOT_W) ? CMP_A : ps2mf_pkg::QUOT_W;
  localparam int PROD_W = 12;

  ps2mf_pkg::ctl_state_t state;
  ps2mf_pkg::ctl_state_t state_next;

  logic [ADDR_W-1:0] wr_slot;
  logic [ADDR_W-1:0] rd_slot;
  logic [CNT_W-1:0]  held;
  logic [CNT_W-1:0]  held_next;
  logic [RCNT_W-1:0] remaining;
  logic [RCNT_W-1:0] remaining_next;
  logic [1:0]        pend_status;
  logic [1:0]        pend_status_next;

  logic                   in_xfer;
  ps2mf_pkg::frame_t      frame;
  logic                   wr_en;
  logic                   rd_issue;
  logic [ps2mf_pkg::PKT_W-1:0] rd_data;
  ps2mf_pkg::pkt_t        rd_pkt;
  logic                   out_free;
  logic                   out_load;
  logic                   load_pkt;
  logic                   load_last;

  logic [PROD_W-1:0]           prod;
  logic [ps2mf_pkg::QUOT_W-1:0] quot;
  logic [CMP_W-1:0]            quot_c;
  logic [CMP_W-1:0]            held_c;
  logic [CMP_W-1:0]            max_c;
  logic [CMP_W-1:0]            take_a;
  logic [CMP_W-1:0]            take_b;

  assign in_stall = (state != ps2mf_pkg::CS_IDLE);
  assign in_xfer = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;

  ps2mf_framer u_framer (
    .clk        (clk),
    .rst        (rst),
    .byte_valid (in_xfer && !mode),
    .data_byte  (data_byte),
    .frame      (frame)
  );

  assign wr_en = frame.valid && (held < CNT_W'(STORE_PACKETS));

  ps2mf_ram #(
    .WIDTH (ps2mf_pkg::PKT_W),
    .DEPTH (STORE_PACKETS)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_slot),
    .wr_data (frame.pkt),
    .rd_en   (rd_issue),
    .rd_addr (rd_slot),
    .rd_data (rd_data)
  );

  assign rd_pkt = ps2mf_pkg::pkt_t'(rd_data);

  // requested_bytes / 3 as (x * 43) >> 7, exact for 6-bit x
  assign prod = PROD_W'(requested_bytes) * PROD_W'(43);
  assign quot = prod[11:7];

  always_comb begin
    quot_c = CMP_W'(quot);
    held_c = CMP_W'(held);
    max_c = CMP_W'(MAX_READ_PACKETS);
    take_a = (quot_c < held_c) ? quot_c : held_c;
    take_b = (take_a < max_c) ? take_a : max_c;
  end

  always_comb begin
    state_next = state;
    rd_issue = 1'b0;
    out_load = 1'b0;
    load_pkt = 1'b0;
    load_last = 1'b0;
    remaining_next = remaining;
    pend_status_next = pend_status;
    unique case (state)
      ps2mf_pkg::CS_IDLE: begin
        if (in_xfer && mode) begin
          if (held == '0) begin
            pend_status_next = ps2mf_pkg::ST_EMPTY;
            state_next = ps2mf_pkg::CS_STATUS;
          end else if (quot == '0) begin
            pend_status_next = ps2mf_pkg::ST_SHORT;
            state_next = ps2mf_pkg::CS_STATUS;
          end else begin
            rd_issue = 1'b1;
            remaining_next = RCNT_W'(take_b);
            state_next = ps2mf_pkg::CS_DATA;
          end
        end
      end
      ps2mf_pkg::CS_STATUS: begin
        if (out_free) begin
          out_load = 1'b1;
          load_last = 1'b1;
          state_next = ps2mf_pkg::CS_IDLE;
        end
      end
      ps2mf_pkg::CS_DATA: begin
        if (out_free) begin
          out_load = 1'b1;
          load_pkt = 1'b1;
          remaining_next = remaining - RCNT_W'(1);
          if (remaining == RCNT_W'(1)) begin
            load_last = 1'b1;
            state_next = ps2mf_pkg::CS_IDLE;
          end else begin
            rd_issue = 1'b1;
          end
        end
      end
      default: begin
        state_next = ps2mf_pkg::CS_IDLE;
      end
    endcase
  end

  always_comb begin
    held_next = held;
    if (wr_en) begin
      held_next = held + CNT_W'(1);
    end else if (rd_issue) begin
      held_next = held - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ps2mf_pkg::CS_IDLE;
      wr_slot <= '0;
      rd_slot <= '0;
      held <= '0;
      remaining <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      held <= held_next;
      remaining <= remaining_next;
      if (wr_en) begin
        wr_slot <= (wr_slot == ADDR_W'(STORE_PACKETS - 1)) ? '0 : wr_slot + ADDR_W'(1);
      end
      if (rd_issue) begin
        rd_slot <= (rd_slot == ADDR_W'(STORE_PACKETS - 1)) ? '0 : rd_slot + ADDR_W'(1);
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    pend_status <= pend_status_next;
    if (out_load) begin
      status <= load_pkt ? ps2mf_pkg::ST_DELIVERED : pend_status;
      first_byte <= load_pkt ? rd_pkt.b0 : 8'h00;
      second_byte <= load_pkt ? rd_pkt.b1 : 8'h00;
      third_byte <= load_pkt ? rd_pkt.b2 : 8'h00;
      last <= load_last;
    end
  end

`ifndef ASSERT_OFF
  a_held_bound: assert property (@(posedge clk) disable iff (rst)
    held <= CNT_W'(STORE_PACKETS))
    else $error("packet count exceeds store depth");

  a_read_nonempty: assert property (@(posedge clk) disable iff (rst)
    rd_issue |-> (held != '0))
    else $error("store read issued with no packet held");

  a_data_remaining: assert property (@(posedge clk) disable iff (rst)
    (state == ps2mf_pkg::CS_DATA) |-> (remaining != '0))
    else $error("drain state with nothing left to send");

  a_last_ends_read: assert property (@(posedge clk) disable iff (rst)
    (out_load && load_last) |=> (state == ps2mf_pkg::CS_IDLE) && last && out_valid)
    else $error("final transfer did not return sequencer to idle");
`endif

endmodule

// ===== dv/tb_ps2_mouse_packet_fifo_unit.sv =====
// Testbench for the PS/2 mouse packet store: directed table and random traffic.
module tb_ps2_mouse_packet_fifo_unit;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int STORE = 256;
  localparam int MAX_RD = 16;
  localparam int SPAN = 2 * STORE;
  localparam int LIMIT = 200000;
  localparam int IDLE_PCT = 18;
  localparam int RANDOM_ITEMS = 305;

  typedef struct packed {
    logic [1:0]      status;
    ps2mf_pkg::pkt_t pkt;
    logic            last;
  } reply_t;

  typedef struct packed {
    logic       m;
    logic [7:0] d;
    logic [5:0] r;
    logic       typed;
    logic [1:0] st;
  } dir_row_t;

  // typed rows carry a fixed single reply (zero bytes, last set)
  localparam int N_DIR = 25;
  localparam dir_row_t DIRECTED [N_DIR] = '{
    '{1'b1, 8'h00, 6'd48, 1'b1, ps2mf_pkg::ST_EMPTY},
    '{1'b1, 8'h00, 6'd0,  1'b1, ps2mf_pkg::ST_EMPTY},
    '{1'b1, 8'hFF, 6'd63, 1'b1, ps2mf_pkg::ST_EMPTY},
    '{1'b0, 8'h00, 6'd0,  1'b0, ps2mf_pkg::ST_DELIVERED},
    '{1'b0, 8'hF7, 6'd63, 1'b0, ps2mf_pkg::ST_DELIVERED},
    '{1'b0, 8'h08, 6'd0,  1'b0, ps2mf_pkg::ST_DELIVERED},
    '{1'b0, 8'h00, 6'd0,  1'b0, ps2mf_pkg::ST_DELIVERED},
    '{1'b0, 8'hFF, 6'd0,  1'b0, ps2mf_pkg::ST_DELIVERED},
    '{1'b1, 8'h00, 6'd2,  1'b1, ps2mf_pkg::ST_SHORT},
    '{1'b1, 8'h00, 6'd0,  1'b1, ps2mf_pkg::ST_SHORT},
    '{1'b0, 8'hFF, 6'd0,  1'b0, ps2mf_pkg::ST_DELIVERED},
    '{1'b1, 8'h00, 6'd1,  1'b1, ps2mf_pkg::ST_SHORT},
    '{1'b0, 8'hF7, 6'd0,  1'b0, ps2mf_pkg::ST_DELIVERED},
    '{1'b0, 8'h00, 6'd0,  1'b0, ps2mf_pkg::ST_DELIVERED},
    '{1'b0, 8'h0F, 6'd0,  1'b0, ps2mf_pkg::ST_DELIVERED},
    '{1'b0, 8'h80, 6'd0,  1'b0, ps2mf_pkg::ST_DELIVERED},
    '{1'b0, 8'h7F, 6'd0,  1'b0, ps2mf_pkg::ST_DELIVERED},
    '{1'b1, 8'h00, 6'd3,  1'b0, ps2mf_pkg::ST_DELIVERED},
    '{1'b1, 8'h00, 6'd63, 1'b0, ps2mf_pkg::ST_DELIVERED},
    '{1'b1, 8'hFF, 6'd3,  1'b1, ps2mf_pkg::ST_EMPTY},
    '{1'b0, 8'h08, 6'd0,  1'b0, ps2mf_pkg::ST_DELIVERED},
    '{1'b0, 8'h55, 6'd0,  1'b0, ps2mf_pkg::ST_DELIVERED},
    '{1'b0, 8'hAA, 6'd0,  1'b0, ps2mf_pkg::ST_DELIVERED},
    '{1'b1, 8'h00, 6'd5,  1'b0, ps2mf_pkg::ST_DELIVERED},
    '{1'b1, 8'h00, 6'd48, 1'b1, ps2mf_pkg::ST_EMPTY}
  };

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic       mode = 1'b0;
  logic [7:0] data_byte = 8'h00;
  logic [5:0] requested_bytes = 6'd0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [1:0] status;
  logic [7:0] first_byte;
  logic [7:0] second_byte;
  logic [7:0] third_byte;
  logic       last;

  ps2_mouse_packet_fifo_unit #(
    .STORE_PACKETS(STORE),
    .MAX_READ_PACKETS(MAX_RD)
  ) u_dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .mode(mode),
    .data_byte(data_byte),
    .requested_bytes(requested_bytes),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .status(status),
    .first_byte(first_byte),
    .second_byte(second_byte),
    .third_byte(third_byte),
    .last(last)
  );

  // predictor state
  ps2mf_pkg::phase_t ph = ps2mf_pkg::PH_FIRST;
  logic [7:0]        hold0 = 8'h00;
  logic [7:0]        hold1 = 8'h00;
  ps2mf_pkg::pkt_t   ring [STORE];
  int unsigned       wr_ptr = 0;
  int unsigned       rd_ptr = 0;

  reply_t step_replies[$];
  reply_t awaited_replies[$];

  int  cyc = 0;
  int  fails = 0;
  int  items_sent = 0;
  int  checked = 0;
  int  dropped = 0;
  int  empty_replies = 0;
  int  short_replies = 0;
  bit  no_gaps = 1'b0;

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic int unsigned slot(input int unsigned p);
    return (p >= STORE) ? p - STORE : p;
  endfunction

  function automatic int unsigned bump(input int unsigned p);
    return (p + 1 >= SPAN) ? 0 : p + 1;
  endfunction

  function automatic int unsigned held_packets();
    return (wr_ptr >= rd_ptr) ? wr_ptr - rd_ptr : wr_ptr + SPAN - rd_ptr;
  endfunction

  function automatic void frame_or_drain(input logic m, input logic [7:0] d,
                                         input logic [5:0] r);
    int unsigned avail;
    int unsigned cnt;
    reply_t      rep;
    step_replies.delete();
    if (!m) begin
      case (ph)
        ps2mf_pkg::PH_SECOND: begin
          hold1 = d;
          ph = ps2mf_pkg::PH_THIRD;
        end
        ps2mf_pkg::PH_THIRD: begin
          ph = ps2mf_pkg::PH_FIRST;
          if (held_packets() < STORE) begin
            ring[slot(wr_ptr)] = '{hold0, hold1, d};
            wr_ptr = bump(wr_ptr);
          end else begin
            dropped++;
          end
        end
        default: begin
          if ((d & ps2mf_pkg::SYNC_MASK) != 8'h00) begin
            hold0 = d;
            ph = ps2mf_pkg::PH_SECOND;
          end else begin
            ph = ps2mf_pkg::PH_FIRST;
          end
        end
      endcase
    end else begin
      avail = held_packets();
      cnt = r / 3;
      rep.pkt = '0;
      rep.last = 1'b1;
      if (avail == 0) begin
        rep.status = ps2mf_pkg::ST_EMPTY;
        step_replies.push_back(rep);
        empty_replies++;
      end else if (cnt == 0) begin
        rep.status = ps2mf_pkg::ST_SHORT;
        step_replies.push_back(rep);
        short_replies++;
      end else begin
        if (cnt > avail) cnt = avail;
        if (cnt > MAX_RD) cnt = MAX_RD;
        for (int unsigned i = 0; i < cnt; i++) begin
          rep.status = ps2mf_pkg::ST_DELIVERED;
          rep.pkt = ring[slot(rd_ptr)];
          rep.last = (i + 1 == cnt);
          rd_ptr = bump(rd_ptr);
          step_replies.push_back(rep);
        end
      end
    end
  endfunction

  task automatic send_item(input logic m, input logic [7:0] d, input logic [5:0] r,
                           input logic typed, input logic [1:0] st);
    reply_t rep;
    while (!no_gaps && $urandom_range(0, 99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    mode <= m;
    data_byte <= d;
    requested_bytes <= r;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    frame_or_drain(m, d, r);
    if (typed) begin
      rep.status = st;
      rep.pkt = '0;
      rep.last = 1'b1;
      awaited_replies.push_back(rep);
    end else begin
      foreach (step_replies[i]) awaited_replies.push_back(step_replies[i]);
    end
    items_sent++;
  endtask

  task automatic send_read();
    logic [5:0] req;
    req = ($urandom_range(0, 3) == 0) ? 6'($urandom_range(0, 2)) : 6'($urandom_range(0, 63));
    send_item(1'b1, 8'($urandom), req, 1'b0, ps2mf_pkg::ST_DELIVERED);
  endtask

  task automatic send_packet(input bit interleave);
    send_item(1'b0, 8'($urandom) | ps2mf_pkg::SYNC_MASK, 6'($urandom), 1'b0,
              ps2mf_pkg::ST_DELIVERED);
    if (interleave && $urandom_range(0, 9) == 0) send_read();
    send_item(1'b0, 8'($urandom), 6'($urandom), 1'b0, ps2mf_pkg::ST_DELIVERED);
    if (interleave && $urandom_range(0, 9) == 0) send_read();
    send_item(1'b0, 8'($urandom), 6'($urandom), 1'b0, ps2mf_pkg::ST_DELIVERED);
  endtask

  // sender holds off until every outstanding reply is out
  task automatic hold_until_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (awaited_replies.size() != 0);
  endtask

  task automatic report_mismatch(input string what);
    fails++;
    if (fails <= 50) $display("mismatch at cycle %0d: %s", cyc, what);
  endtask

  always @(posedge clk) begin
    cyc <= cyc + 1;
    if (cyc >= LIMIT) begin
      $display("timeout after %0d cycles, %0d replies outstanding", cyc,
               awaited_replies.size());
      $display("FAILED: results differ");
      $finish;
    end
  end

  always @(posedge clk) begin
    out_stall <= !no_gaps && ($urandom_range(0, 99) < IDLE_PCT);
  end

  always @(posedge clk) begin
    reply_t want;
    if (!rst && out_valid && !out_stall) begin
      if (awaited_replies.size() == 0) begin
        report_mismatch($sformatf("unexpected transfer st=%0d %h %h %h last=%0b",
                                  status, first_byte, second_byte, third_byte, last));
      end else begin
        want = awaited_replies.pop_front();
        checked++;
        if (status !== want.status || first_byte !== want.pkt.b0 ||
            second_byte !== want.pkt.b1 || third_byte !== want.pkt.b2 ||
            last !== want.last)
          report_mismatch($sformatf("got st=%0d %h %h %h last=%0b, want st=%0d %h %h %h last=%0b",
                                    status, first_byte, second_byte, third_byte, last,
                                    want.status, want.pkt.b0, want.pkt.b1, want.pkt.b2,
                                    want.last));
      end
    end
  end

  initial begin
    int goal;
    int pick;
    int start;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (int i = 0; i < N_DIR; i++)
      send_item(DIRECTED[i].m, DIRECTED[i].d, DIRECTED[i].r, DIRECTED[i].typed,
                DIRECTED[i].st);
    hold_until_drained();

    start = items_sent;
    goal = start + RANDOM_ITEMS;
    while (items_sent < goal) begin
      no_gaps = (items_sent >= start + 120) && (items_sent < start + 200);
      pick = $urandom_range(0, 99);
      if (pick < 62) send_packet(1'b1);
      else if (pick < 86) send_read();
      else send_item(1'b0, 8'($urandom), 6'($urandom), 1'b0, ps2mf_pkg::ST_DELIVERED);
    end
    no_gaps = 1'b0;
    in_valid <= 1'b0;

    while (awaited_replies.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("covered %0d items and %0d checked results, directed corners then random",
             items_sent, checked);
    $display("%0d empty and %0d short replies, %0d packets dropped on a full store",
             empty_replies, short_replies, dropped);
    if (fails == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
